FILE: src/assert_macros.svh
// Assertion helper macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: src/sfbl_pkg.sv
// ----------------------------------------------------------------------------
// sfbl_pkg
// Operation codes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfbl_pkg;
	localparam logic [3:0] ACT_INS_FIRST = 4'd0;
	localparam logic [3:0] ACT_INS_LAST  = 4'd1;
	localparam logic [3:0] ACT_INS_AT    = 4'd2;
	localparam logic [3:0] ACT_INS_ADDR  = 4'd3;
	localparam logic [3:0] ACT_INS_SIZE  = 4'd4;
	localparam logic [3:0] ACT_RM_FIRST  = 4'd5;
	localparam logic [3:0] ACT_RM_LAST   = 4'd6;
	localparam logic [3:0] ACT_RM_AT     = 4'd7;
	localparam logic [3:0] ACT_RM_ADDR   = 4'd8;
	localparam logic [3:0] ACT_RM_PREV   = 4'd9;
	localparam logic [3:0] ACT_RM_NEXT   = 4'd10;
	localparam logic [3:0] ACT_READ_AT   = 4'd11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Per-entry compare results of the datapath, sampled by the controller
	typedef struct packed {
		logic addr_lt;    // entry address < key address
		logic size_lt;    // entry size < key size
		logic addr_eq;    // entry address == key address
		logic end_eq;     // entry address + size == key address
		logic tag_eq;     // entry tag == key tag
	} sfbl_stat_t;

	// Datapath commands
	typedef struct packed {
		logic rd_en;      // read the entry at rd_idx
		logic wr_key;     // write the key fields at wr_idx
		logic wr_data;    // write the read-back entry at wr_idx
		logic hold_out;   // capture read data into the output fields
		logic clr_out;    // zero the output fields
	} sfbl_cmd_t;
endpackage

FILE: src/sfbl_ram.sv
// ----------------------------------------------------------------------------
// sfbl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

FILE: src/sfbl_dp.sv
// ----------------------------------------------------------------------------
// sfbl_dp
// Datapath: entry memory, key registers, entry compare and output fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfbl_dp #(
	parameter int DEPTH     = 64,
	parameter int ADDR_BITS = 32,
	parameter int TAG_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic [31:0]              key_addr,
	input  logic [31:0]              key_size,
	input  logic [15:0]              key_tag,
	input  sfbl_pkg::sfbl_cmd_t      cmd,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	output sfbl_pkg::sfbl_stat_t     stat,
	output logic [31:0]              out_addr,
	output logic [31:0]              out_size,
	output logic [15:0]              out_tag
);
	import sfbl_pkg::*;

	localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

	logic [AW-1:0] ka_q;
	logic [31:0]   ks_q;
	logic [TW-1:0] kt_q;
	logic [AW-1:0] ra;
	logic [31:0]   rs;
	logic [TW-1:0] rt;
	logic [AW-1:0] ends;

	always_ff @(posedge clk) begin
		if (load) begin
			ka_q <= key_addr[AW-1:0];
			ks_q <= key_size;
			kt_q <= key_tag[TW-1:0];
		end
		if (cmd.clr_out) begin
			out_addr <= '0;
			out_size <= '0;
			out_tag  <= '0;
		end else if (cmd.hold_out) begin
			out_addr <= 32'(ra);
			out_size <= rs;
			out_tag  <= 16'(rt);
		end
	end

	sfbl_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_addr (
		.clk(clk), .we(cmd.wr_key | cmd.wr_data), .waddr(wr_idx),
		.wdata(cmd.wr_key ? ka_q : ra), .re(cmd.rd_en), .raddr(rd_idx), .rdata(ra));
	sfbl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_size (
		.clk(clk), .we(cmd.wr_key | cmd.wr_data), .waddr(wr_idx),
		.wdata(cmd.wr_key ? ks_q : rs), .re(cmd.rd_en), .raddr(rd_idx), .rdata(rs));
	sfbl_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tag (
		.clk(clk), .we(cmd.wr_key | cmd.wr_data), .waddr(wr_idx),
		.wdata(cmd.wr_key ? kt_q : rt), .re(cmd.rd_en), .raddr(rd_idx), .rdata(rt));

	assign ends = ra + rs[AW-1:0];

	always_comb begin
		stat.addr_lt = ra < ka_q;
		stat.size_lt = rs < ks_q;
		stat.addr_eq = ra == ka_q;
		stat.end_eq  = ends == ka_q;
		stat.tag_eq  = rt == kt_q;
	end
endmodule

FILE: src/sfbl_ctrl.sv
// ----------------------------------------------------------------------------
// sfbl_ctrl
// Controller: decodes the operation, scans the list, shifts entries with a
// memory read then a write per entry and issues the result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfbl_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [3:0]               action,
	input  logic [6:0]               position,
	output logic                     load,
	output sfbl_pkg::sfbl_cmd_t      cmd,
	output logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [$clog2(DEPTH)-1:0] wr_idx,
	input  sfbl_pkg::sfbl_stat_t     stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [6:0]               count
);
	import sfbl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_CHECK, S_SHR, S_SHL, S_PUT, S_OUT
	} state_t;

	state_t     state_q;
	logic [3:0] act_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;     // scan index / target
	logic [CW-1:0] mv_q;      // shift cursor
	logic       phase_q;
	logic       take;
	logic       last;
	logic       hit;
	logic       stop;
	logic [CW-1:0] pos_w;

	assign take = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign count = 7'(cnt_q);
	assign load = take;
	assign pos_w = (position > 7'(cnt_q)) ? cnt_q : CW'(position);
	assign last = idx_q + CW'(1) >= cnt_q;

	// Scan stop conditions per operation, valid in S_CHECK
	always_comb begin
		case (act_q)
			ACT_INS_ADDR: stop = !stat.addr_lt;
			ACT_INS_SIZE: stop = !stat.size_lt;
			ACT_RM_ADDR:  stop = stat.addr_eq;
			ACT_RM_PREV:  stop = stat.tag_eq || stat.end_eq || last;
			ACT_RM_NEXT:  stop = stat.tag_eq || stat.addr_eq || last;
			default:      stop = 1'b1;
		endcase
		hit = (act_q == ACT_RM_PREV || act_q == ACT_RM_NEXT) ? stat.tag_eq : stop;
	end

	always_comb begin
		cmd = '0;
		rd_idx = idx_q[IW-1:0];
		wr_idx = idx_q[IW-1:0];
		case (state_q)
			S_IDLE: cmd.clr_out = take;
			S_SCAN: cmd.rd_en = 1'b1;
			S_SHR: begin
				rd_idx = IW'(mv_q - CW'(1));
				wr_idx = mv_q[IW-1:0];
				cmd.rd_en = !phase_q;
				cmd.wr_data = phase_q;
			end
			S_SHL: begin
				rd_idx = IW'(mv_q + CW'(1));
				wr_idx = mv_q[IW-1:0];
				cmd.rd_en = !phase_q;
				cmd.wr_data = phase_q;
			end
			S_PUT: cmd.wr_key = 1'b1;
			S_CHECK: cmd.hold_out = act_q >= ACT_RM_FIRST && hit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			act_q   <= '0;
			idx_q   <= '0;
			mv_q    <= '0;
			phase_q <= 1'b0;
			status  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (take) begin
					act_q   <= action;
					status  <= ST_OK;
					idx_q   <= '0;
					phase_q <= 1'b0;
					state_q <= S_OUT;
					if (action <= ACT_INS_SIZE) begin
						if (cnt_q == CW'(DEPTH))
							status <= ST_FULL;
						else if (action == ACT_INS_FIRST) begin
							idx_q <= '0; mv_q <= cnt_q; state_q <= S_SHR;
						end else if (action == ACT_INS_LAST) begin
							idx_q <= cnt_q; mv_q <= cnt_q; state_q <= S_SHR;
						end else if (action == ACT_INS_AT) begin
							idx_q <= pos_w; mv_q <= cnt_q; state_q <= S_SHR;
						end else if (cnt_q == '0) begin
							state_q <= S_SHR; mv_q <= '0;
						end else
							state_q <= S_SCAN;
					end else if (action <= ACT_READ_AT) begin
						if (cnt_q == '0)
							status <= ST_EMPTY;
						else if (action == ACT_RM_LAST) begin
							idx_q <= cnt_q - CW'(1); state_q <= S_SCAN;
						end else if (action == ACT_RM_AT || action == ACT_READ_AT) begin
							if (position >= 7'(cnt_q))
								status <= ST_RANGE;
							else begin
								idx_q <= CW'(position); state_q <= S_SCAN;
							end
						end else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: state_q <= S_CHECK;
				S_CHECK: begin
					if (act_q == ACT_INS_ADDR || act_q == ACT_INS_SIZE) begin
						if (stop || last) begin
							if (!stop) idx_q <= idx_q + CW'(1);
							mv_q <= cnt_q;
							state_q <= S_SHR;
						end else begin
							idx_q <= idx_q + CW'(1); state_q <= S_SCAN;
						end
					end else if (act_q == ACT_READ_AT)
						state_q <= S_OUT;
					else if (!stop && !last) begin
						idx_q <= idx_q + CW'(1); state_q <= S_SCAN;
					end else if (hit) begin
						mv_q <= idx_q; state_q <= S_SHL;
					end else begin
						status <= ST_EMPTY; state_q <= S_OUT;
					end
				end
				S_SHR: begin
					if (mv_q == idx_q) state_q <= S_PUT;
					else begin
						phase_q <= !phase_q;
						if (phase_q) mv_q <= mv_q - CW'(1);
					end
				end
				S_PUT: begin
					cnt_q <= cnt_q + CW'(1); state_q <= S_OUT;
				end
				S_SHL: begin
					if (mv_q + CW'(1) >= cnt_q) begin
						cnt_q <= cnt_q - CW'(1); state_q <= S_OUT;
					end else begin
						phase_q <= !phase_q;
						if (phase_q) mv_q <= mv_q + CW'(1);
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "count beyond depth")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")
	`ASSERT_IMPL(a_no_write_idle, clk, arst_n, state_q == S_IDLE, !cmd.wr_key && !cmd.wr_data, "write while idle")
endmodule

FILE: src/sorted_free_block_list.sv
// Rejected or unknown items go straight to the result; reads fetch one entry and end
// inserts write the key without shifting; searches read and compare each entry visited,
// shifts move each entry by a memory read then write. One item in flight at a time.
// The result register holds until taken; the next item is accepted the cycle after.
// arst_n clears the count and controller; entry memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_free_block_list
// Ordered free-block list with positional, ordered and search operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sorted_free_block_list #(
	parameter int DEPTH     = 64,
	parameter int ADDR_BITS = 32,
	parameter int TAG_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [6:0]  position,
	input  logic [31:0] block_addr,
	input  logic [31:0] block_size,
	input  logic [15:0] block_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] out_addr,
	output logic [31:0] out_size,
	output logic [15:0] out_tag,
	output logic [6:0]  count
);
	import sfbl_pkg::*;

	logic                     load;
	sfbl_cmd_t                cmd;
	sfbl_stat_t               stat;
	logic [$clog2(DEPTH)-1:0] rd_idx;
	logic [$clog2(DEPTH)-1:0] wr_idx;

	sfbl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .position(position), .load(load), .cmd(cmd),
		.rd_idx(rd_idx), .wr_idx(wr_idx), .stat(stat), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .count(count));

	sfbl_dp #(.DEPTH(DEPTH), .ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS)) u_dp (
		.clk(clk), .load(load), .key_addr(block_addr), .key_size(block_size),
		.key_tag(block_tag), .cmd(cmd), .rd_idx(rd_idx), .wr_idx(wr_idx),
		.stat(stat), .out_addr(out_addr), .out_size(out_size), .out_tag(out_tag));
endmodule
